// File: hw/rtl/acs_pkg.sv
// Shared types, constants and joining tables for the Arabic contextual shaper.
package acs_pkg;

  localparam int CP_W = 21;

  localparam logic [CP_W-1:0] LAM          = 21'h000644;
  localparam logic [CP_W-1:0] TATWEEL      = 21'h000640;
  localparam logic [CP_W-1:0] FIRST_LETTER = 21'h000621;
  localparam logic [CP_W-1:0] LAST_LETTER  = 21'h00064A;

  localparam logic [1:0] CLS_NONE  = 2'd0;
  localparam logic [1:0] CLS_NONJ  = 2'd1;
  localparam logic [1:0] CLS_RIGHT = 2'd2;
  localparam logic [1:0] CLS_DUAL  = 2'd3;

  localparam logic [1:0] JOIN_TAB [42] = '{
    CLS_NONJ, CLS_RIGHT, CLS_RIGHT, CLS_RIGHT, CLS_RIGHT, CLS_DUAL, CLS_RIGHT,
    CLS_DUAL, CLS_RIGHT, CLS_DUAL, CLS_DUAL, CLS_DUAL, CLS_DUAL, CLS_DUAL,
    CLS_RIGHT, CLS_RIGHT, CLS_RIGHT, CLS_RIGHT, CLS_DUAL, CLS_DUAL, CLS_DUAL,
    CLS_DUAL, CLS_DUAL, CLS_DUAL, CLS_DUAL, CLS_DUAL, CLS_NONE, CLS_NONE,
    CLS_NONE, CLS_NONE, CLS_NONE, CLS_DUAL, CLS_DUAL, CLS_DUAL, CLS_DUAL,
    CLS_DUAL, CLS_DUAL, CLS_DUAL, CLS_DUAL, CLS_RIGHT, CLS_RIGHT, CLS_DUAL
  };

  localparam logic [15:0] ISO_TAB [42] = '{
    16'hFE80, 16'hFE81, 16'hFE83, 16'hFE85, 16'hFE87, 16'hFE89, 16'hFE8D,
    16'hFE8F, 16'hFE93, 16'hFE95, 16'hFE99, 16'hFE9D, 16'hFEA1, 16'hFEA5,
    16'hFEA9, 16'hFEAB, 16'hFEAD, 16'hFEAF, 16'hFEB1, 16'hFEB5, 16'hFEB9,
    16'hFEBD, 16'hFEC1, 16'hFEC5, 16'hFEC9, 16'hFECD, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0640, 16'hFED1, 16'hFED5, 16'hFED9,
    16'hFEDD, 16'hFEE1, 16'hFEE5, 16'hFEE9, 16'hFEED, 16'hFEEF, 16'hFEF1
  };

  typedef struct packed {
    logic [CP_W-1:0] codepoint;
    logic            last;
  } in_item_t;

  typedef struct packed {
    logic [CP_W-1:0] shaped;
    logic            final_item;
  } out_item_t;

  // Context of the nearest following letter that is not a combining mark.
  typedef struct packed {
    logic       next_jr;
    logic       alef_vld;
    logic [1:0] alef_sel;
  } ctx_t;

  function automatic logic in_letters(input logic [CP_W-1:0] cp);
    return (cp >= FIRST_LETTER) && (cp <= LAST_LETTER);
  endfunction

  function automatic logic [5:0] letter_off(input logic [CP_W-1:0] cp);
    logic [CP_W-1:0] diff;
    diff = cp - FIRST_LETTER;
    return diff[5:0];
  endfunction

  function automatic logic [1:0] join_cls(input logic [CP_W-1:0] cp);
    logic [1:0] cls;
    cls = CLS_NONE;
    if (in_letters(cp)) begin
      cls = JOIN_TAB[letter_off(cp)];
    end
    return cls;
  endfunction

  function automatic logic [15:0] iso_form(input logic [CP_W-1:0] cp);
    logic [15:0] iso;
    iso = '0;
    if (in_letters(cp)) begin
      iso = ISO_TAB[letter_off(cp)];
    end
    return iso;
  endfunction

  function automatic logic joins_left(input logic [1:0] cls);
    return cls == CLS_DUAL;
  endfunction

  function automatic logic joins_right(input logic [1:0] cls);
    return (cls == CLS_RIGHT) || (cls == CLS_DUAL);
  endfunction

  function automatic logic is_mark(input logic [CP_W-1:0] cp);
    return ((cp >= 21'h000610) && (cp <= 21'h00061A)) ||
           ((cp >= 21'h00064B) && (cp <= 21'h00065F)) ||
           (cp == 21'h000670) ||
           ((cp >= 21'h0006D6) && (cp <= 21'h0006DC)) ||
           ((cp >= 21'h0006DF) && (cp <= 21'h0006E4)) ||
           ((cp >= 21'h0006E7) && (cp <= 21'h0006E8)) ||
           ((cp >= 21'h0006EA) && (cp <= 21'h0006ED));
  endfunction

  function automatic ctx_t alef_ctx(input logic [CP_W-1:0] cp);
    ctx_t c;
    c.next_jr  = joins_right(join_cls(cp));
    c.alef_vld = 1'b1;
    case (cp)
      21'h000622: c.alef_sel = 2'd0;
      21'h000623: c.alef_sel = 2'd1;
      21'h000625: c.alef_sel = 2'd2;
      21'h000627: c.alef_sel = 2'd3;
      default: begin
        c.alef_sel = 2'd0;
        c.alef_vld = 1'b0;
      end
    endcase
    return c;
  endfunction

  function automatic logic [15:0] lig_iso(input logic [1:0] sel);
    logic [15:0] lig;
    case (sel)
      2'd0:    lig = 16'hFEF5;
      2'd1:    lig = 16'hFEF7;
      2'd2:    lig = 16'hFEF9;
      default: lig = 16'hFEFB;
    endcase
    return lig;
  endfunction

endpackage

// File: hw/rtl/arabic_contextual_shaper_unit.sv
// Top level of the Arabic contextual shaper: collection, context pass and shaping pass.
//
//   Channel  Direction  Payload      Handshake
//   in_      input      in_item_t    in_valid / in_stall
//   out_     output     out_item_t   out_valid / out_stall
//
// Collection takes one transaction per cycle. After the transaction marked last, a
// backward pass reads the N stored codepoints through the single read port, then a
// forward pass gives one result per cycle when out_stall stays low (none for an Alef
// merged into a Lam-Alef ligature). in_stall is high during both passes.
// Reset is synchronous and active low; it clears control state but not the memories.
// out_stall holds the result register and pauses the forward pass.
module arabic_contextual_shaper_unit #(
  parameter int MAX_CODEPOINTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  acs_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output acs_pkg::out_item_t  out_data
);
  import acs_pkg::*;

  localparam int AW = $clog2(MAX_CODEPOINTS);
  localparam int CW = $clog2(MAX_CODEPOINTS + 1);
  localparam int PW = CW + 1;

  localparam logic [1:0] S_COLLECT = 2'd0;
  localparam logic [1:0] S_BWD     = 2'd1;
  localparam logic [1:0] S_FWD     = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            stopped_r, stopped_nxt;
  logic            issuing_r, issuing_nxt;
  logic            rvld_r, rvld_nxt;
  logic            prev_jl_r, prev_jl_nxt;
  logic            skip_r, skip_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [AW-1:0]   ptr_r, ptr_nxt;
  logic [AW-1:0]   ridx_r, ridx_nxt;
  logic            rlast_r, rlast_nxt;
  logic            rpen_r, rpen_nxt;
  ctx_t            ninfo_r, ninfo_nxt;
  out_item_t       out_data_r, out_data_nxt;

  logic            in_acc;
  logic            store_en;
  logic [CW-1:0]   count_inc;
  logic [CW-1:0]   count_after;
  logic            consume;
  logic            rd_issue;
  logic [PW-1:0]   ptr_w;
  logic [CP_W-1:0] text_q;
  ctx_t            ctx_q;
  logic [CP_W-1:0] sh_cp;
  logic            sh_emit;
  logic            sh_skip;
  logic            sh_jl;

  assign in_stall    = state_r != S_COLLECT;
  assign in_acc      = in_valid && !in_stall;
  assign store_en    = in_acc && !stopped_r && (in_data.codepoint != '0);
  assign count_inc   = count_r + CW'(1);
  assign count_after = store_en ? count_inc : count_r;
  assign ptr_w       = PW'(ptr_r);

  assign consume  = rvld_r && ((state_r == S_BWD) || !sh_emit || !out_valid_r || !out_stall);
  assign rd_issue = issuing_r && (!rvld_r || consume);

  acs_ram #(
    .WIDTH (CP_W),
    .DEPTH (MAX_CODEPOINTS)
  ) u_text_ram (
    .clk     (clk),
    .we      (store_en),
    .waddr   (count_r[AW-1:0]),
    .wdata   (in_data.codepoint),
    .re      (rd_issue),
    .raddr   (ptr_r),
    .rdata_r (text_q)
  );

  acs_ram #(
    .WIDTH ($bits(ctx_t)),
    .DEPTH (MAX_CODEPOINTS)
  ) u_ctx_ram (
    .clk     (clk),
    .we      ((state_r == S_BWD) && rvld_r),
    .waddr   (ridx_r),
    .wdata   (ninfo_r),
    .re      (rd_issue && (state_r == S_FWD)),
    .raddr   (ptr_r),
    .rdata_r (ctx_q)
  );

  acs_shape u_shape (
    .cur      (text_q),
    .prev_jl  (prev_jl_r),
    .ctx      (ctx_q),
    .skip_in  (skip_r),
    .shaped   (sh_cp),
    .emit     (sh_emit),
    .skip_out (sh_skip),
    .jl_out   (sh_jl)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    stopped_nxt   = stopped_r;
    issuing_nxt   = issuing_r;
    rvld_nxt      = rvld_r;
    prev_jl_nxt   = prev_jl_r;
    skip_nxt      = skip_r;
    ptr_nxt       = ptr_r;
    ridx_nxt      = ridx_r;
    rlast_nxt     = rlast_r;
    rpen_nxt      = rpen_r;
    ninfo_nxt     = ninfo_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (rd_issue) begin
      rvld_nxt = 1'b1;
      ridx_nxt = ptr_r;
      rpen_nxt = (ptr_w + PW'(2)) == PW'(count_r);
      if (state_r == S_BWD) begin
        rlast_nxt = ptr_r == '0;
        ptr_nxt   = ptr_r - AW'(1);
      end else begin
        rlast_nxt = (ptr_w + PW'(1)) == PW'(count_r);
        ptr_nxt   = ptr_r + AW'(1);
      end
      if (rlast_nxt) begin
        issuing_nxt = 1'b0;
      end
    end else if (consume) begin
      rvld_nxt = 1'b0;
    end

    case (state_r)
      S_COLLECT: begin
        if (in_acc) begin
          if (!stopped_r) begin
            if (in_data.codepoint == '0) begin
              stopped_nxt = 1'b1;
            end else begin
              count_nxt = count_inc;
              if (count_inc == CW'(MAX_CODEPOINTS)) begin
                stopped_nxt = 1'b1;
              end
            end
          end
          if (in_data.last) begin
            if (count_after == '0) begin
              count_nxt   = '0;
              stopped_nxt = 1'b0;
            end else begin
              state_nxt   = S_BWD;
              ptr_nxt     = AW'(count_after - CW'(1));
              issuing_nxt = 1'b1;
              ninfo_nxt   = '0;
            end
          end
        end
      end
      S_BWD: begin
        if (rvld_r) begin
          if (!is_mark(text_q)) begin
            ninfo_nxt = alef_ctx(text_q);
          end
          if (rlast_r) begin
            state_nxt   = S_FWD;
            ptr_nxt     = '0;
            issuing_nxt = 1'b1;
            prev_jl_nxt = 1'b0;
            skip_nxt    = 1'b0;
          end
        end
      end
      S_FWD: begin
        if (consume) begin
          prev_jl_nxt = sh_jl;
          skip_nxt    = sh_skip;
          if (sh_emit) begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.shaped     = sh_cp;
            out_data_nxt.final_item = rlast_r || (rpen_r && sh_skip);
          end
          if (rlast_r) begin
            state_nxt   = S_COLLECT;
            count_nxt   = '0;
            stopped_nxt = 1'b0;
            skip_nxt    = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_COLLECT;
      count_r     <= '0;
      stopped_r   <= 1'b0;
      issuing_r   <= 1'b0;
      rvld_r      <= 1'b0;
      prev_jl_r   <= 1'b0;
      skip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      stopped_r   <= stopped_nxt;
      issuing_r   <= issuing_nxt;
      rvld_r      <= rvld_nxt;
      prev_jl_r   <= prev_jl_nxt;
      skip_r      <= skip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    ridx_r     <= ridx_nxt;
    rlast_r    <= rlast_nxt;
    rpen_r     <= rpen_nxt;
    ninfo_r    <= ninfo_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_CODEPOINTS))
    else $error("Stored count exceeds the store depth.");

  a_read_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (rvld_r || issuing_r) |-> (state_r == S_BWD || state_r == S_FWD))
    else $error("Memory read in flight outside a shaping pass.");

  a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    issuing_r |-> (ptr_w < PW'(count_r)))
    else $error("Read address beyond the stored count.");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FWD && consume && rlast_r) |=>
      (state_r == S_COLLECT && count_r == '0 && !stopped_r))
    else $error("Run did not return to collection after its final transaction.");

endmodule

// File: hw/rtl/acs_ram.sv
// Single-port-write, single-port-read synchronous memory with registered read data.
module acs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/acs_shape.sv
// Contextual form selection and Lam-Alef ligature logic for one stored codepoint.
module acs_shape (
  input  logic [acs_pkg::CP_W-1:0] cur,
  input  logic                     prev_jl,
  input  acs_pkg::ctx_t            ctx,
  input  logic                     skip_in,
  output logic [acs_pkg::CP_W-1:0] shaped,
  output logic                     emit,
  output logic                     skip_out,
  output logic                     jl_out
);
  import acs_pkg::*;

  logic [1:0]  cls;
  logic        mark;
  logic        pc;
  logic        nc;
  logic [15:0] letter;
  logic [15:0] lig;

  always_comb begin
    cls    = join_cls(cur);
    mark   = is_mark(cur);
    pc     = prev_jl && joins_right(cls);
    nc     = ctx.next_jr && joins_left(cls);
    letter = iso_form(cur) + {14'b0, nc, pc};
    lig    = lig_iso(ctx.alef_sel) + {15'b0, prev_jl};

    shaped   = cur;
    emit     = 1'b1;
    skip_out = 1'b0;
    jl_out   = prev_jl;
    if (mark) begin
      skip_out = skip_in;
    end else if (skip_in) begin
      emit   = 1'b0;
      jl_out = joins_left(cls);
    end else begin
      jl_out = joins_left(cls);
      if ((cur == LAM) && ctx.alef_vld) begin
        shaped   = {5'b0, lig};
        skip_out = 1'b1;
      end else if ((cls != CLS_NONE) && (cur != TATWEEL)) begin
        shaped = {5'b0, letter};
      end
    end
  end

endmodule
